@@ hw/rtl/adjacent_transposition_permutation_gen_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the adjacent transposition permutation generator
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ADJACENT_TRANSPOSITION_PERMUTATION_GEN_CORE_DEFINES_SVH
`define ADJACENT_TRANSPOSITION_PERMUTATION_GEN_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define AJTPG_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ajtpg assertion failed");
`define AJTPG_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) \
    else $error("ajtpg assertion failed");
`else
`define AJTPG_ASSERT(label, prop)
`define AJTPG_ASSERT_NEXT(label, pre, post)
`endif

`endif

@@ hw/rtl/ajtpg_pkg.sv @@
// ----------------------------------------------------------------------------
// ajtpg_pkg
// Shared constants and result type of the permutation move generator.
// ----------------------------------------------------------------------------
package ajtpg_pkg;

  localparam int unsigned MaxElementsDef = 16;
  localparam int unsigned CountW         = 5;
  localparam int unsigned PosW           = 4;
  localparam int unsigned CountResetVal  = 4;

  typedef struct packed {
    logic [PosW-1:0] first_pos;
    logic [PosW-1:0] second_pos;
    logic            cycle_end;
  } move_t;

endpackage

@@ hw/rtl/adjacent_transposition_permutation_gen_core.sv @@
// ----------------------------------------------------------------------------
// adjacent_transposition_permutation_gen_core
// Emits one adjacent transposition per request, walking all permutations.
//
//   channel  direction  handshake                    payload
//   in       input      in_valid_i / in_stall_o      restart_i
//   out      output     out_valid_o / out_stall_i    first_pos_o, second_pos_o,
//                                                    cycle_end_o
//   cfg      input      cfg_we_i                     element_count_i
//
// one request per cycle while in_stall_o is low; its move is registered on acceptance
// move decode and counter step are one combinational pass on the counter
// reset clears the counter and sets the element count to four
// in_stall_o rises only while a held result is stalled downstream
// ----------------------------------------------------------------------------
`include "adjacent_transposition_permutation_gen_core_defines.svh"

module adjacent_transposition_permutation_gen_core import ajtpg_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = MaxElementsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] element_count_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              restart_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [PosW-1:0]   first_pos_o,
  output logic [PosW-1:0]   second_pos_o,
  output logic              cycle_end_o
);

  localparam int unsigned DigW      = (MAX_ELEMENTS > 2) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned LvlW      = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned ClampW    = (CountW > LvlW) ? CountW + 1 : LvlW + 1;
  localparam int unsigned CountRstV =
      (CountResetVal > MAX_ELEMENTS) ? MAX_ELEMENTS : CountResetVal;

  logic [DigW-1:0]       digit_q [MAX_ELEMENTS+1];
  logic [DigW-1:0]       digit_d [MAX_ELEMENTS+1];
  logic [MAX_ELEMENTS:0] dir_q, dir_d;
  logic [LvlW-1:0]       count_q, count_d;
  logic                  accept;
  logic                  out_ready;
  move_t                 move;
  move_t                 out_move;

  assign in_stall_o = !out_ready;
  assign accept     = in_valid_i && out_ready;

  always_comb begin
    if (element_count_i == '0) begin
      count_d = LvlW'(1);
    end else if (ClampW'(element_count_i) > ClampW'(MAX_ELEMENTS)) begin
      count_d = LvlW'(MAX_ELEMENTS);
    end else begin
      count_d = LvlW'(element_count_i);
    end
  end

  ajtpg_move #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .DIG_W        (DigW),
    .LVL_W        (LvlW)
  ) u_move (
    .count_i   (count_q),
    .restart_i (restart_i),
    .digit_i   (digit_q),
    .dir_i     (dir_q),
    .digit_o   (digit_d),
    .dir_o     (dir_d),
    .move_o    (move)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= LvlW'(CountRstV);
      dir_q   <= '0;
      for (int j = 0; j <= MAX_ELEMENTS; j++) begin
        digit_q[j] <= '0;
      end
    end else if (cfg_we_i) begin
      count_q <= count_d;
      dir_q   <= '0;
      for (int j = 0; j <= MAX_ELEMENTS; j++) begin
        digit_q[j] <= '0;
      end
    end else if (accept) begin
      dir_q <= dir_d;
      for (int j = 0; j <= MAX_ELEMENTS; j++) begin
        digit_q[j] <= digit_d[j];
      end
    end
  end

  ajtpg_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .move_i  (move),
    .ready_o (out_ready),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .move_o  (out_move)
  );

  assign first_pos_o  = out_move.first_pos;
  assign second_pos_o = out_move.second_pos;
  assign cycle_end_o  = out_move.cycle_end;

  `AJTPG_ASSERT_NEXT(a_restart_noop, accept && restart_i, out_valid_o && first_pos_o == '0 && second_pos_o == '0)
  `AJTPG_ASSERT(a_adjacent_pair, out_valid_o |-> (first_pos_o == second_pos_o || first_pos_o == PosW'(second_pos_o + PosW'(1)) || second_pos_o == PosW'(first_pos_o + PosW'(1))))
  `AJTPG_ASSERT_NEXT(a_restart_not_last, accept && restart_i && count_q > LvlW'(1) && !cfg_we_i, !cycle_end_o)
  `AJTPG_ASSERT_NEXT(a_single_always_last, accept && count_q == LvlW'(1), cycle_end_o && first_pos_o == '0)

endmodule

@@ hw/rtl/ajtpg_move.sv @@
// ----------------------------------------------------------------------------
// ajtpg_move
// Decodes the current move from the mixed-radix counter and computes the
// counter's next value.
// ----------------------------------------------------------------------------
module ajtpg_move import ajtpg_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = MaxElementsDef,
  parameter int unsigned DIG_W        = 4,
  parameter int unsigned LVL_W        = 5
) (
  input  logic [LVL_W-1:0] count_i,
  input  logic             restart_i,
  input  logic [DIG_W-1:0] digit_i [MAX_ELEMENTS+1],
  input  logic [MAX_ELEMENTS:0] dir_i,
  output logic [DIG_W-1:0] digit_o [MAX_ELEMENTS+1],
  output logic [MAX_ELEMENTS:0] dir_o,
  output move_t            move_o
);

  localparam int unsigned SumW = (LVL_W + 1 > PosW) ? LVL_W + 1 : PosW;

  logic [DIG_W-1:0] d   [MAX_ELEMENTS+1];
  logic [MAX_ELEMENTS:0] dir;
  logic [DIG_W-1:0] nd  [MAX_ELEMENTS+1];
  logic [MAX_ELEMENTS:0] ndir;
  logic [DIG_W-1:0] sel_r;
  logic [LVL_W-1:0] sel_k;
  logic             sel_dir;
  logic             found;
  logic [LVL_W-1:0] offset;
  logic             last;
  logic             carry;
  logic [SumW-1:0]  first_s;
  logic [SumW-1:0]  second_s;

  always_comb begin
    logic act;
    logic nz;
    logic top;
    logic inc;
    for (int j = 0; j <= MAX_ELEMENTS; j++) begin
      d[j]   = (restart_i || j < 2) ? '0 : digit_i[j];
      dir[j] = (restart_i || j < 2) ? 1'b0 : dir_i[j];
    end

    // priority encoder over active levels, direction count above the winner
    found   = 1'b0;
    sel_r   = '0;
    sel_k   = '0;
    sel_dir = 1'b0;
    offset  = '0;
    last    = 1'b1;
    carry   = 1'b1;
    for (int j = 0; j <= MAX_ELEMENTS; j++) begin
      nd[j]   = '0;
      ndir[j] = 1'b0;
    end
    for (int j = MAX_ELEMENTS; j >= 2; j--) begin
      act = (LVL_W'(j) <= count_i);
      nz  = act && (d[j] != '0);
      top = (d[j] == DIG_W'(j - 1));
      if (nz && !found) begin
        sel_r   = d[j];
        sel_k   = LVL_W'(j);
        sel_dir = dir[j];
      end
      found = found | nz;
      if (act && !found && dir[j]) begin
        offset = offset + LVL_W'(1);
      end
      // counter increment, least significant digit at level n
      inc = act && carry;
      if (act) begin
        last  = last && top;
        carry = inc && top;
      end
      nd[j]   = inc ? (top ? '0 : d[j] + DIG_W'(1)) : d[j];
      ndir[j] = dir[j] ^ (inc && top);
    end

    if (!found) begin
      first_s  = '0;
      second_s = '0;
    end else if (sel_dir) begin
      first_s  = SumW'(sel_r) - SumW'(1);
      second_s = SumW'(sel_r);
    end else begin
      first_s  = SumW'(sel_k) - SumW'(sel_r);
      second_s = SumW'(sel_k) - SumW'(sel_r) - SumW'(1);
    end
    first_s  = first_s + SumW'(offset);
    second_s = second_s + SumW'(offset);

    for (int j = 0; j <= MAX_ELEMENTS; j++) begin
      digit_o[j] = last ? '0 : nd[j];
      dir_o[j]   = last ? 1'b0 : ndir[j];
    end
    move_o.first_pos  = first_s[PosW-1:0];
    move_o.second_pos = second_s[PosW-1:0];
    move_o.cycle_end  = last;
  end

endmodule

@@ hw/rtl/ajtpg_out_reg.sv @@
// ----------------------------------------------------------------------------
// ajtpg_out_reg
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
module ajtpg_out_reg import ajtpg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  load_i,
  input  move_t move_i,
  output logic  ready_o,
  output logic  valid_o,
  input  logic  stall_i,
  output move_t move_o
);

  logic  valid_q, valid_d;
  move_t move_q;

  assign ready_o = !valid_q || !stall_i;
  assign valid_d = load_i || (valid_q && stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      move_q <= move_i;
    end
  end

  assign valid_o = valid_q;
  assign move_o  = move_q;

endmodule
